// File: sv/dprf_pkg.sv
`timescale 1ns / 1ps
package dprf_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 6;
    localparam int STATUS_W  = 2;

    localparam logic [LEN_W-1:0]    MAX_LEN_RST = 6'd63;
    localparam logic [BYTE_W-1:0]   DELIM       = 8'h00;

    localparam logic                OP_RECV     = 1'b0;
    localparam logic                OP_REQ      = 1'b1;

    localparam logic [STATUS_W-1:0] ST_BYTE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DISCARD  = 2'd2;

    typedef struct packed {
        logic                wr_en;
        logic                scan_init;
        logic                scan_adv;
        logic                raddr_emit;
        logic                discard;
        logic                emit_adv;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic is_delim;
        logic oversize;
        logic emit_last;
        logic out_free;
    } t_sts;

endpackage

// File: sv/dprf_ram.sv
`timescale 1ns / 1ps
module dprf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/dprf_datapath.sv
`timescale 1ns / 1ps
module dprf_datapath #(
    parameter int DEPTH = dprf_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dprf_pkg::t_cmd                i_cmd,
    output dprf_pkg::t_sts                o_sts,
    input  logic [dprf_pkg::BYTE_W-1:0]   i_rx_byte,
    input  logic                          i_cfg_we,
    input  logic [dprf_pkg::LEN_W-1:0]    i_cfg_data,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [dprf_pkg::STATUS_W-1:0] o_status,
    output logic [dprf_pkg::BYTE_W-1:0]   o_data_byte,
    output logic                          o_last,
    output logic [dprf_pkg::LEN_W-1:0]    o_pkt_len
);

    localparam int PW = $clog2(DEPTH);

    logic [PW-1:0]                   r_wr_ptr;
    logic [PW-1:0]                   r_rd_ptr;
    logic [PW-1:0]                   r_scan_ptr;
    logic [PW-1:0]                   r_cnt;
    logic [PW-1:0]                   r_k;
    logic [dprf_pkg::LEN_W-1:0]      r_max;
    logic                            r_out_valid;
    logic [dprf_pkg::STATUS_W-1:0]   r_out_status;
    logic [dprf_pkg::BYTE_W-1:0]     r_out_data;
    logic                            r_out_last;
    logic [dprf_pkg::LEN_W-1:0]      r_out_len;

    logic [PW:0]                     fill_wide;
    logic [PW-1:0]                   fill;
    logic [PW-1:0]                   len;
    logic [dprf_pkg::LEN_W-1:0]      len_ext;
    logic                            full;
    logic                            we;
    logic [PW-1:0]                   raddr;
    logic [dprf_pkg::BYTE_W-1:0]     rdata;
    logic                            out_free;

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        q = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
        return q;
    endfunction

    assign fill_wide = {1'b0, r_wr_ptr} - {1'b0, r_rd_ptr}
                     + ((r_wr_ptr < r_rd_ptr) ? (PW+1)'(DEPTH) : '0);
    assign fill      = fill_wide[PW-1:0];
    assign len       = r_cnt + PW'(1);
    assign len_ext   = dprf_pkg::LEN_W'(len);
    assign full      = (f_next(r_wr_ptr) == r_rd_ptr);
    assign we        = i_cmd.wr_en && !full;
    assign raddr     = i_cmd.raddr_emit ? r_rd_ptr : r_scan_ptr;
    assign out_free  = !r_out_valid || !i_out_stall;

    dprf_ram #(
        .WIDTH (dprf_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_rx_byte),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_max       <= dprf_pkg::MAX_LEN_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (we) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (i_cmd.discard) begin
                r_rd_ptr <= f_next(r_scan_ptr);
            end else if (i_cmd.emit_adv) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            if (i_cfg_we) begin
                r_max <= i_cfg_data;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_scan_ptr <= r_rd_ptr;
            r_cnt      <= '0;
            r_k        <= '0;
        end else if (i_cmd.scan_adv) begin
            r_scan_ptr <= f_next(r_scan_ptr);
            r_cnt      <= r_cnt + PW'(1);
        end else if (i_cmd.emit_adv) begin
            r_k <= r_k + PW'(1);
        end
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            case (i_cmd.out_status)
                dprf_pkg::ST_BYTE: begin
                    r_out_data <= rdata;
                    r_out_last <= (r_k == r_cnt);
                    r_out_len  <= len_ext;
                end
                dprf_pkg::ST_DISCARD: begin
                    r_out_data <= '0;
                    r_out_last <= 1'b1;
                    r_out_len  <= len_ext;
                end
                default: begin
                    r_out_data <= '0;
                    r_out_last <= 1'b1;
                    r_out_len  <= '0;
                end
            endcase
        end
    end

    assign o_sts.scan_done = (r_cnt == fill);
    assign o_sts.is_delim  = (rdata == dprf_pkg::DELIM);
    assign o_sts.oversize  = (len_ext > r_max);
    assign o_sts.emit_last = (r_k == r_cnt);
    assign o_sts.out_free  = out_free;

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_data_byte     = r_out_data;
    assign o_last          = r_out_last;
    assign o_pkt_len       = r_out_len;

endmodule

// File: sv/dprf_ctrl.sv
`timescale 1ns / 1ps
module dprf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_op,
    output logic           o_in_stall,
    input  dprf_pkg::t_sts i_sts,
    output dprf_pkg::t_cmd o_cmd,
    output logic           o_idle
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN_RD  = 3'd1;
    localparam logic [2:0] S_SCAN_CHK = 3'd2;
    localparam logic [2:0] S_NONE     = 3'd3;
    localparam logic [2:0] S_DECIDE   = 3'd4;
    localparam logic [2:0] S_EMIT_RD  = 3'd5;
    localparam logic [2:0] S_EMIT_OUT = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == dprf_pkg::OP_RECV) begin
                        o_cmd.wr_en = 1'b1;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                n_state = i_sts.scan_done ? S_NONE : S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (i_sts.is_delim) begin
                    n_state = S_DECIDE;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                    n_state        = S_SCAN_RD;
                end
            end
            S_NONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = dprf_pkg::ST_NONE;
                    n_state          = S_IDLE;
                end
            end
            S_DECIDE: begin
                if (!i_sts.oversize) begin
                    n_state = S_EMIT_RD;
                end else if (i_sts.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = dprf_pkg::ST_DISCARD;
                    o_cmd.discard    = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_EMIT_RD: begin
                o_cmd.raddr_emit = 1'b1;
                n_state          = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                o_cmd.raddr_emit = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = dprf_pkg::ST_BYTE;
                    o_cmd.emit_adv   = 1'b1;
                    n_state          = i_sts.emit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

// File: sv/delimited_packet_rx_fifo.sv
`timescale 1ns / 1ps
// Receive ring of DEPTH bytes (DEPTH-1 usable) that returns zero-terminated
// packets. A receive transaction stores the byte, or drops it when the ring
// is full. A request transaction scans the ring byte by byte through the
// single read port of the ring memory, then either answers with one result
// (no packet, or oversized packet discarded) or emits the packet byte by
// byte, delimiter included. After a request is taken the input stalls until
// the result or the last packet byte is loaded into the output register,
// and an output stall prolongs the wait.
// The config write sets the longest packet that is delivered and is taken
// only while no request is in progress.
module delimited_packet_rx_fifo #(
    parameter int DEPTH = dprf_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_op,
    input  logic [dprf_pkg::BYTE_W-1:0]   i_rx_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [dprf_pkg::STATUS_W-1:0] o_status,
    output logic [dprf_pkg::BYTE_W-1:0]   o_data_byte,
    output logic                          o_last,
    output logic [dprf_pkg::LEN_W-1:0]    o_pkt_len,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dprf_pkg::LEN_W-1:0]    i_cfg_data
);

    dprf_pkg::t_cmd cmd;
    dprf_pkg::t_sts sts;
    logic           idle;

    assign o_cfg_ready = idle;

    dprf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_idle     (idle)
    );

    dprf_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_rx_byte       (i_rx_byte),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_data_byte     (o_data_byte),
        .o_last          (o_last),
        .o_pkt_len       (o_pkt_len)
    );

`ifndef ASSERT_OFF
    a_stall_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !idle |-> o_in_stall)
        else $error("input taken while a request is in progress");

    a_only_bytes_continue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (o_status == dprf_pkg::ST_BYTE))
        else $error("non-byte result without last");

    a_none_has_no_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == dprf_pkg::ST_NONE)
        |-> (o_pkt_len == '0 && o_data_byte == '0))
        else $error("no-packet result carries data");

    a_found_has_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == dprf_pkg::ST_BYTE || o_status == dprf_pkg::ST_DISCARD))
        |-> (o_pkt_len != '0))
        else $error("found packet with zero length");
`endif

endmodule

// File: tb/sv/packet_rx_checker.sv
`timescale 1ns / 1ps
module packet_rx_checker #(
    parameter int DEPTH = dprf_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_op,
    input  logic [dprf_pkg::BYTE_W-1:0]   i_rx_byte,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [dprf_pkg::STATUS_W-1:0] i_status,
    input  logic [dprf_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                          i_last,
    input  logic [dprf_pkg::LEN_W-1:0]    i_pkt_len,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [dprf_pkg::LEN_W-1:0]    i_cfg_data,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_ring_bytes
);

    typedef struct packed {
        logic [dprf_pkg::STATUS_W-1:0] status;
        logic [dprf_pkg::BYTE_W-1:0]   data_byte;
        logic                          last;
        logic [dprf_pkg::LEN_W-1:0]    pkt_len;
    } t_pkt_result;

    logic [dprf_pkg::BYTE_W-1:0] ring_mem [DEPTH];
    int                          wr_ptr;
    int                          rd_ptr;
    logic [dprf_pkg::LEN_W-1:0]  max_len;
    t_pkt_result                 expected_q [$];

    function automatic int ring_used();
        return (wr_ptr + DEPTH - rd_ptr) % DEPTH;
    endfunction

    task automatic push_result(input logic [dprf_pkg::STATUS_W-1:0] st,
                               input logic [dprf_pkg::BYTE_W-1:0] b,
                               input logic fin, input int len);
        t_pkt_result r;
        r.status    = st;
        r.data_byte = b;
        r.last      = fin;
        r.pkt_len   = dprf_pkg::LEN_W'(len);
        expected_q.push_back(r);
    endtask

    task automatic predict_transaction(input logic op,
                                       input logic [dprf_pkg::BYTE_W-1:0] rx);
        int used;
        int found_len;
        int i;
        if (op == dprf_pkg::OP_RECV) begin
            if ((wr_ptr + 1) % DEPTH != rd_ptr) begin
                ring_mem[wr_ptr] = rx;
                wr_ptr = (wr_ptr + 1) % DEPTH;
            end
        end else begin
            used      = ring_used();
            found_len = 0;
            for (i = 0; i < used; i++) begin
                if (found_len == 0 && ring_mem[(rd_ptr + i) % DEPTH] == dprf_pkg::DELIM) begin
                    found_len = i + 1;
                end
            end
            if (found_len == 0) begin
                push_result(dprf_pkg::ST_NONE, '0, 1'b1, 0);
            end else if (found_len > int'(max_len)) begin
                rd_ptr = (rd_ptr + found_len) % DEPTH;
                push_result(dprf_pkg::ST_DISCARD, '0, 1'b1, found_len);
            end else begin
                for (i = 0; i < found_len; i++) begin
                    push_result(dprf_pkg::ST_BYTE, ring_mem[rd_ptr], i == found_len - 1,
                                found_len);
                    rd_ptr = (rd_ptr + 1) % DEPTH;
                end
            end
        end
    endtask

    function automatic void compare_field(input string field_name, input int want,
                                          input int got);
        if (want != got) begin
            o_errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field_name, want, got);
        end
    endfunction

    task automatic check_result();
        t_pkt_result want;
        if (expected_q.size() == 0) begin
            o_errors++;
            $display("%0t: expected no result, actual st %0d byte %0d last %0d len %0d",
                     $time, i_status, i_data_byte, i_last, i_pkt_len);
        end else begin
            want = expected_q.pop_front();
            compare_field("status", want.status, i_status);
            compare_field("data_byte", want.data_byte, i_data_byte);
            compare_field("last", want.last, i_last);
            compare_field("pkt_len", want.pkt_len, i_pkt_len);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wr_ptr  = 0;
            rd_ptr  = 0;
            max_len = dprf_pkg::MAX_LEN_RST;
            expected_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_result();
            end
            if (i_cfg_valid && i_cfg_ready) begin
                max_len = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                predict_transaction(i_op, i_rx_byte);
            end
        end
        o_pending    = expected_q.size();
        o_ring_bytes = ring_used();
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

    localparam int CYCLE_LIMIT      = 600000;
    localparam int SETTLE_CYCLES    = 20;
    localparam int FINAL_CYCLES     = 300;
    localparam int LONG_HOLD_CYCLES = 500;
    localparam int RANDOM_PHASES    = 6;
    localparam int PHASE_ITEMS      = 8;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic                          op;
    logic [dprf_pkg::BYTE_W-1:0]   rx_byte;
    logic                          out_valid;
    logic                          out_stall;
    logic [dprf_pkg::STATUS_W-1:0] status;
    logic [dprf_pkg::BYTE_W-1:0]   data_byte;
    logic                          last;
    logic [dprf_pkg::LEN_W-1:0]    pkt_len;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [dprf_pkg::LEN_W-1:0]    cfg_data;

    int errors;
    int pending;
    int ring_bytes;
    int cycle_count;
    int items_sent;
    int send_idle_pct;
    int recv_stall_pct;
    bit long_hold_req;

    delimited_packet_rx_fifo dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_op            (op),
        .i_rx_byte       (rx_byte),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_status        (status),
        .o_data_byte     (data_byte),
        .o_last          (last),
        .o_pkt_len       (pkt_len),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    packet_rx_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_op            (op),
        .i_rx_byte       (rx_byte),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_status        (status),
        .i_data_byte     (data_byte),
        .i_last          (last),
        .i_pkt_len       (pkt_len),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_ring_bytes    (ring_bytes)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        bit hold_done;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req && !hold_done) begin
                hold_done = 1'b1;
                out_stall = 1'b1;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                out_stall = (recv_stall_pct > 0) && ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    task automatic send_item(input logic item_op,
                             input logic [dprf_pkg::BYTE_W-1:0] item_byte);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        op       = item_op;
        rx_byte  = item_byte;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_request();
        send_item(dprf_pkg::OP_REQ, dprf_pkg::BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic send_packet(input int len);
        repeat (len - 1) send_item(dprf_pkg::OP_RECV, dprf_pkg::BYTE_W'($urandom_range(1, 255)));
        send_item(dprf_pkg::OP_RECV, dprf_pkg::DELIM);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [dprf_pkg::LEN_W-1:0] value);
        drain();
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // terminate any open tail and pull packets until the ring is empty
    task automatic flush_ring();
        int guard;
        drain();
        guard = 0;
        while (ring_bytes != 0 && guard < 2 * dprf_pkg::DEPTH_DEF) begin
            send_item(dprf_pkg::OP_RECV, dprf_pkg::DELIM);
            send_request();
            drain();
            guard++;
        end
    endtask

    // fill the ring with short packets, which can overflow it, then drain it
    task automatic flood();
        int n;
        n = $urandom_range(18, 22);
        repeat (n) send_packet($urandom_range(2, 5));
        repeat (n + 4) send_request();
    endtask

    task automatic random_sequence();
        int kind;
        int len;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 7);
            if (ring_bytes + len > dprf_pkg::DEPTH_DEF - 8) begin
                flush_ring();
            end
            send_packet(len);
            if ($urandom_range(0, 3) != 0) begin
                send_request();
            end
        end else if (kind < 85) begin
            send_request();
        end else if (kind < 97) begin
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_item(dprf_pkg::OP_RECV, dprf_pkg::DELIM);
                end else begin
                    send_item(dprf_pkg::OP_RECV, dprf_pkg::BYTE_W'($urandom_range(0, 255)));
                end
            end
        end else begin
            flush_ring();
            send_packet($urandom_range(40, 63));
            send_request();
        end
    endtask

    function automatic logic [dprf_pkg::LEN_W-1:0] phase_max_len(input int phase);
        case (phase)
            0:       return 6'd8;
            1:       return 6'd63;
            2:       return 6'd1;
            3:       return 6'd25;
            4:       return 6'd4;
            default: return 6'd63;
        endcase
    endfunction

    initial begin
        int  start_count;
        bit  paused;
        i_rst_n        = 1'b0;
        in_valid       = 1'b0;
        op             = dprf_pkg::OP_RECV;
        rx_byte        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        long_hold_req  = 1'b0;
        items_sent     = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        write_cfg(dprf_pkg::MAX_LEN_RST);
        send_request();
        send_item(dprf_pkg::OP_RECV, 8'hFF);
        send_item(dprf_pkg::OP_RECV, 8'h01);
        send_item(dprf_pkg::OP_RECV, dprf_pkg::DELIM);
        send_item(dprf_pkg::OP_REQ, 8'hFF);
        send_item(dprf_pkg::OP_RECV, dprf_pkg::DELIM);
        send_item(dprf_pkg::OP_REQ, 8'h00);
        send_item(dprf_pkg::OP_RECV, 8'h80);
        send_item(dprf_pkg::OP_RECV, 8'h7F);
        send_item(dprf_pkg::OP_REQ, 8'h00);
        send_item(dprf_pkg::OP_RECV, dprf_pkg::DELIM);
        send_item(dprf_pkg::OP_REQ, 8'h00);
        send_item(dprf_pkg::OP_RECV, 8'h55);
        send_item(dprf_pkg::OP_RECV, 8'hAA);
        send_item(dprf_pkg::OP_RECV, dprf_pkg::DELIM);

        // zero limit: every packet found is dropped as oversized
        write_cfg('0);
        send_item(dprf_pkg::OP_REQ, 8'h00);
        send_item(dprf_pkg::OP_RECV, dprf_pkg::DELIM);
        send_item(dprf_pkg::OP_REQ, 8'h00);

        write_cfg(6'd1);
        send_item(dprf_pkg::OP_RECV, dprf_pkg::DELIM);
        send_item(dprf_pkg::OP_REQ, 8'h00);
        send_item(dprf_pkg::OP_RECV, 8'h12);
        send_item(dprf_pkg::OP_RECV, dprf_pkg::DELIM);
        send_item(dprf_pkg::OP_REQ, 8'h00);
        send_item(dprf_pkg::OP_REQ, 8'h00);

        paused = 1'b0;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_cfg(phase_max_len(phase));
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            if (phase == 0) begin
                flood();
            end
            if (phase == 2) begin
                long_hold_req = 1'b1;
                send_packet(4);
                send_request();
                send_request();
            end
            start_count = items_sent;
            while (items_sent - start_count < PHASE_ITEMS) begin
                random_sequence();
                if (phase == 3 && !paused && items_sent - start_count > PHASE_ITEMS / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        repeat (FINAL_CYCLES) @(negedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
